// ----- sv/multi_channel_mailbox_with_acl_core_defines.svh -----
// ----------------------------------------------------------------------------
// Mailbox assertion macros
// Shared concurrent assertion forms used by the mailbox top level.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_MAILBOX_WITH_ACL_CORE_DEFINES_SVH
`define MULTI_CHANNEL_MAILBOX_WITH_ACL_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCMB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MCMB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/mcmb_pkg.sv -----
// ----------------------------------------------------------------------------
// Mailbox package
// Sizes, request and status codes, and the command passed front to back.
// ----------------------------------------------------------------------------
package mcmb_pkg;

  localparam int CHANNELS    = 8;
  localparam int RING_DEPTH  = 16;
  localparam int MSG_W       = 64;
  localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IDX_W       = $clog2(RING_DEPTH);
  localparam int FILL_W      = $clog2(RING_DEPTH + 1);
  localparam int ADDR_W      = CH_W + IDX_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_POLL  = 2'd1,
    ACT_ACL   = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_CHANNEL = 3'd1,
    ST_NOT_AUTH    = 3'd2,
    ST_FULL        = 3'd3,
    ST_EMPTY       = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_PUSH = 2'd1,
    CMD_POP  = 2'd2
  } op_t;

  typedef struct packed {
    op_t                op;
    status_t            status;
    logic [ADDR_W-1:0]  addr;
    logic [MSG_W-1:0]   data;
  } cmd_t;

endpackage

// ----- sv/multi_channel_mailbox_with_acl_core.sv -----
// Path: an accepted request is written into the command queue, then into the back end's output register.
// Throughput: one request per cycle while the command queue has room; the front end's counter update and the single
// ring memory port each handle one request a cycle.
// Reset: synchronous, active low; clears all ring counters, access masks and queue state.
// The ring memory is not cleared, since an entry is only read after it was written.
// ----------------------------------------------------------------------------
// Multi-channel mailbox with access control
// Per-channel 64-bit message rings; writes are guarded by per-channel 64-bit task masks.
// ----------------------------------------------------------------------------
`include "multi_channel_mailbox_with_acl_core_defines.svh"

module multi_channel_mailbox_with_acl_core import mcmb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_action,
  input  logic [3:0]        in_channel,
  input  logic [MSG_W-1:0]  in_message,
  input  logic signed [6:0] in_task_id,
  input  logic              in_allow,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_status,
  output logic [MSG_W-1:0]  out_read_data
);

  // The front end classifies each request against the channel state it owns
  // and updates that state right away, so the next request sees it without
  // waiting for the ring memory.
  logic f_valid;
  logic f_ready;
  cmd_t f_cmd;

  // Commands wait here while the output register is stalled, so the front end
  // keeps accepting requests until the queue fills.
  logic b_valid;
  logic b_ready;
  cmd_t b_cmd;

  mcmb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_action  (in_action),
    .in_channel (in_channel),
    .in_message (in_message),
    .in_task_id (in_task_id),
    .in_allow   (in_allow),
    .q_valid    (f_valid),
    .q_ready    (f_ready),
    .q_cmd      (f_cmd)
  );

  mcmb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_cmd    (b_cmd)
  );

  // The back end performs the memory write or read and keeps the response in
  // its output register; read data comes straight from the registered read.
  mcmb_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (b_valid),
    .cmd_ready     (b_ready),
    .cmd           (b_cmd),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_read_data (out_read_data)
  );

  // A request taken into an empty queue is waiting for the back end in the next cycle.
  `MCMB_ASSERT_NEXT(a_push_lands, clk, rst_n, in_valid && in_ready && !b_valid, b_valid, "accepted request missing from queue")
  // A waiting command with a free output register becomes a response next cycle.
  `MCMB_ASSERT_NEXT(a_issue_lands, clk, rst_n, b_valid && (!out_valid || out_ready), out_valid, "issued command produced no response")
  // Only a successful poll returns data.
  `MCMB_ASSERT_NOW(a_data_zero, clk, rst_n, out_valid && out_status != ST_OK, out_read_data == '0, "nonzero data on failed request")

endmodule

// ----- sv/mcmb_front.sv -----
// ----------------------------------------------------------------------------
// Mailbox front end
// Accepts requests, checks them against the channel counters and access
// masks, updates that state and issues one command per request.
// ----------------------------------------------------------------------------
module mcmb_front import mcmb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_action,
  input  logic [3:0]        in_channel,
  input  logic [MSG_W-1:0]  in_message,
  input  logic signed [6:0] in_task_id,
  input  logic              in_allow,
  output logic              q_valid,
  input  logic              q_ready,
  output cmd_t              q_cmd
);

  logic [MSG_W-1:0]  mask_r [CHANNELS];
  logic [IDX_W-1:0]  rd_idx_r [CHANNELS];
  logic [IDX_W-1:0]  wr_idx_r [CHANNELS];
  logic [FILL_W-1:0] fill_r [CHANNELS];

  logic [MSG_W-1:0]  mask_nxt;
  logic [IDX_W-1:0]  rd_idx_nxt;
  logic [IDX_W-1:0]  wr_idx_nxt;
  logic [FILL_W-1:0] fill_nxt;

  action_t          act;
  logic [CH_W-1:0]  ch;
  logic             ch_ok;
  logic             trusted;
  logic [5:0]       tid;
  logic [MSG_W-1:0] tid_bit;
  logic             accept;

  assign act     = action_t'(in_action);
  assign ch      = in_channel[CH_W-1:0];
  assign ch_ok   = {1'b0, in_channel} < 5'(CHANNELS);
  assign trusted = in_task_id[6];
  assign tid     = in_task_id[5:0];
  assign tid_bit = {{(MSG_W-1){1'b0}}, 1'b1} << tid;
  assign in_ready = q_ready;
  assign q_valid  = in_valid;
  assign accept   = in_valid && q_ready;

  always_comb begin
    q_cmd.op     = CMD_NONE;
    q_cmd.status = ST_OK;
    q_cmd.addr   = {ch, wr_idx_r[ch]};
    q_cmd.data   = in_message;
    mask_nxt     = mask_r[ch];
    rd_idx_nxt   = rd_idx_r[ch];
    wr_idx_nxt   = wr_idx_r[ch];
    fill_nxt     = fill_r[ch];
    priority if (act == ACT_NONE) begin
      q_cmd.status = ST_OK;
    end else if (!ch_ok) begin
      q_cmd.status = ST_BAD_CHANNEL;
    end else begin
      unique case (act)
        ACT_WRITE: begin
          priority if (!trusted && !mask_r[ch][tid]) begin
            q_cmd.status = ST_NOT_AUTH;
          end else if (fill_r[ch] >= FILL_W'(RING_DEPTH)) begin
            q_cmd.status = ST_FULL;
          end else begin
            q_cmd.op   = CMD_PUSH;
            wr_idx_nxt = (wr_idx_r[ch] == IDX_W'(RING_DEPTH - 1)) ? '0
                                                                    : wr_idx_r[ch] + 1'b1;
            fill_nxt   = fill_r[ch] + 1'b1;
          end
        end
        ACT_POLL: begin
          q_cmd.addr = {ch, rd_idx_r[ch]};
          if (fill_r[ch] == '0) begin
            q_cmd.status = ST_EMPTY;
          end else begin
            q_cmd.op   = CMD_POP;
            rd_idx_nxt = (rd_idx_r[ch] == IDX_W'(RING_DEPTH - 1)) ? '0
                                                                    : rd_idx_r[ch] + 1'b1;
            fill_nxt   = fill_r[ch] - 1'b1;
          end
        end
        ACT_ACL: begin
          if (!trusted) begin
            mask_nxt = in_allow ? (mask_r[ch] | tid_bit) : (mask_r[ch] & ~tid_bit);
          end
        end
        default: begin
          q_cmd.status = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        mask_r[i]   <= '0;
        rd_idx_r[i] <= '0;
        wr_idx_r[i] <= '0;
        fill_r[i]   <= '0;
      end
    end else if (accept && ch_ok) begin
      mask_r[ch]   <= mask_nxt;
      rd_idx_r[ch] <= rd_idx_nxt;
      wr_idx_r[ch] <= wr_idx_nxt;
      fill_r[ch]   <= fill_nxt;
    end
  end

endmodule

// ----- sv/mcmb_queue.sv -----
// ----------------------------------------------------------------------------
// Mailbox command queue
// Small FIFO of commands between the front end and the ring back end.
// ----------------------------------------------------------------------------
module mcmb_queue import mcmb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r;
  logic [QPTR_W-1:0] rptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = count_r != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_cmd    = slot_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ----- sv/mcmb_back.sv -----
// ----------------------------------------------------------------------------
// Mailbox back end
// Carries out ring writes and reads in the message memory and holds the
// response in the output register until it is taken.
// ----------------------------------------------------------------------------
module mcmb_back import mcmb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  cmd_t             cmd,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       out_status,
  output logic [MSG_W-1:0] out_read_data
);

  localparam int MEM_DEPTH = 1 << ADDR_W;

  logic [MSG_W-1:0] ring_mem [MEM_DEPTH];
  logic [MSG_W-1:0] rdata_r;
  logic             pop_r;
  status_t          status_r;
  logic             valid_r;
  logic             issue;

  assign cmd_ready     = !valid_r || out_ready;
  assign issue         = cmd_valid && cmd_ready;
  assign out_valid     = valid_r;
  assign out_status    = status_r;
  assign out_read_data = pop_r ? rdata_r : '0;

  always_ff @(posedge clk) begin
    if (issue && cmd.op == CMD_PUSH) begin
      ring_mem[cmd.addr] <= cmd.data;
    end
    if (issue && cmd.op == CMD_POP) begin
      rdata_r <= ring_mem[cmd.addr];
    end
    if (issue) begin
      status_r <= cmd.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pop_r   <= 1'b0;
    end else if (issue) begin
      valid_r <= 1'b1;
      pop_r   <= cmd.op == CMD_POP;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

endmodule

// ----- verif/mailbox_response_checker.sv -----
// ----------------------------------------------------------------------------
// Mailbox response checker
// Watches the request and response channels of the mailbox, keeps a shadow copy of the
// rings and access masks, and compares every response with its prediction.
// ----------------------------------------------------------------------------
module mailbox_response_checker import mcmb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        in_action,
  input  logic [3:0]        in_channel,
  input  logic [MSG_W-1:0]  in_message,
  input  logic signed [6:0] in_task_id,
  input  logic              in_allow,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [2:0]        out_status,
  input  logic [MSG_W-1:0]  out_read_data,
  output int                mismatch_count,
  output int                outstanding_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_t          status;
    logic [MSG_W-1:0] read_data;
  } response_t;

  logic [MSG_W-1:0]  shadow_ring [CHANNELS][RING_DEPTH];
  logic [IDX_W-1:0]  oldest_slot [CHANNELS];
  logic [IDX_W-1:0]  free_slot [CHANNELS];
  logic [FILL_W-1:0] held_count [CHANNELS];
  logic [63:0]       task_mask [CHANNELS];
  response_t         pending_responses [$];
  int                errors_seen = 0;

  function automatic logic [IDX_W-1:0] wrap_slot(input logic [IDX_W-1:0] slot);
    return (slot == RING_DEPTH - 1) ? '0 : slot + 1'b1;
  endfunction

  // Applies one request to the shadow state and returns the response it earns.
  function automatic response_t predict_mailbox_response(
    input action_t           act,
    input logic [3:0]        ch,
    input logic [MSG_W-1:0]  msg,
    input logic [6:0]        tid,
    input logic              allow
  );
    response_t resp;
    logic      trusted;
    logic [5:0] task_bit;
    resp.status = ST_OK;
    resp.read_data = '0;
    trusted = tid[6];
    task_bit = tid[5:0];
    if (act == ACT_NONE) begin
      resp.status = ST_OK;
    end else if (ch >= CHANNELS) begin
      resp.status = ST_BAD_CHANNEL;
    end else begin
      case (act)
        ACT_WRITE: begin
          if (!trusted && !task_mask[ch][task_bit]) begin
            resp.status = ST_NOT_AUTH;
          end else if (held_count[ch] >= RING_DEPTH) begin
            resp.status = ST_FULL;
          end else begin
            shadow_ring[ch][free_slot[ch]] = msg;
            free_slot[ch] = wrap_slot(free_slot[ch]);
            held_count[ch] = held_count[ch] + 1'b1;
          end
        end
        ACT_POLL: begin
          if (held_count[ch] == 0) begin
            resp.status = ST_EMPTY;
          end else begin
            resp.read_data = shadow_ring[ch][oldest_slot[ch]];
            oldest_slot[ch] = wrap_slot(oldest_slot[ch]);
            held_count[ch] = held_count[ch] - 1'b1;
          end
        end
        default: begin
          if (!trusted) begin
            task_mask[ch][task_bit] = allow;
          end
        end
      endcase
    end
    return resp;
  endfunction

  always @(posedge clk) begin
    response_t want;
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        oldest_slot[c] = '0;
        free_slot[c] = '0;
        held_count[c] = '0;
        task_mask[c] = '0;
      end
      pending_responses.delete();
    end else begin
      // A response leaving at this edge can never belong to a request taken at
      // the same edge, so the compare runs before the new prediction is queued.
      if (out_valid && out_ready) begin
        if (pending_responses.size() == 0) begin
          $error("unexpected response: status %0d read_data %h", out_status, out_read_data);
          errors_seen++;
        end else begin
          want = pending_responses.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            errors_seen++;
          end
          if (out_read_data !== want.read_data) begin
            $error("read_data: expected %h, actual %h", want.read_data, out_read_data);
            errors_seen++;
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_responses.push_back(predict_mailbox_response(action_t'(in_action),
          in_channel, in_message, in_task_id, in_allow));
      end
    end
    mismatch_count <= errors_seen;
    outstanding_count <= pending_responses.size();
  end

endmodule

// ----- verif/multi_channel_mailbox_with_acl_core_test.sv -----
// ----------------------------------------------------------------------------
// Mailbox with access control: block-level test
// Drives directed and random requests into the mailbox through its request
// channel, stalls the response channel, and lets the checker judge results.
// ----------------------------------------------------------------------------
module multi_channel_mailbox_with_acl_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mcmb_pkg::*;

  // Action mixes for one phase of random requests.
  typedef enum int {
    MIX_BALANCED,
    MIX_FILL,
    MIX_DRAIN
  } request_mix_t;

  // Ways the response side can behave over one segment.
  typedef enum int {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PERIODIC
  } stall_mode_t;

  localparam int USEFUL_REQUESTS  = 1250;
  localparam int LONG_STALL_CYCLES = 80;
  localparam int SETTLE_CYCLES    = 8;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic [1:0]        in_action = '0;
  logic [3:0]        in_channel = '0;
  logic [MSG_W-1:0]  in_message = '0;
  logic signed [6:0] in_task_id = '0;
  logic              in_allow = 1'b0;
  logic              out_ready = 1'b0;
  wire               in_ready;
  wire               out_valid;
  wire [2:0]         out_status;
  wire [MSG_W-1:0]   out_read_data;
  int                mismatch_count;
  int                outstanding_count;

  // Set by the stimulus to ask the response side for one long hold-off; the
  // response process clears it when it starts the stall.
  bit                long_stall_req = 1'b0;
  int                useful_sent = 0;
  logic [5:0]        favored_tasks [4];

  multi_channel_mailbox_with_acl_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_channel    (in_channel),
    .in_message    (in_message),
    .in_task_id    (in_task_id),
    .in_allow      (in_allow),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_read_data (out_read_data)
  );

  mailbox_response_checker response_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_channel        (in_channel),
    .in_message        (in_message),
    .in_task_id        (in_task_id),
    .in_allow          (in_allow),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_read_data     (out_read_data),
    .mismatch_count    (mismatch_count),
    .outstanding_count (outstanding_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Presents one request and returns at the edge where it is taken. The
  // payload stays put until then, and valid stays high into the next request.
  task automatic send_request(
    input action_t          act,
    input logic [3:0]       ch,
    input logic [MSG_W-1:0] msg,
    input logic [6:0]       tid,
    input logic             allow
  );
    in_valid <= 1'b1;
    in_action <= act;
    in_channel <= ch;
    in_message <= msg;
    in_task_id <= tid;
    in_allow <= allow;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    useful_sent++;
  endtask

  task automatic pause_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drops valid and waits until every queued prediction has been matched.
  // The first edge is needed because the checker's count is registered.
  task automatic wait_for_all_responses();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (outstanding_count != 0);
  endtask

  // Random request shaped toward valid channels and tasks that tend to hold
  // access, with one favored channel per phase so rings fill up and drain.
  task automatic send_random_request(input request_mix_t mix, input int focus_ch);
    int         pick;
    int         write_cut;
    int         poll_cut;
    action_t    act;
    logic [3:0] ch;
    logic [6:0] tid;
    case (mix)
      MIX_FILL: begin
        write_cut = 65;
        poll_cut = 80;
      end
      MIX_DRAIN: begin
        write_cut = 20;
        poll_cut = 80;
      end
      default: begin
        write_cut = 40;
        poll_cut = 75;
      end
    endcase
    pick = $urandom_range(0, 99);
    if (pick < write_cut) begin
      act = ACT_WRITE;
    end else if (pick < poll_cut) begin
      act = ACT_POLL;
    end else if (pick < 96) begin
      act = ACT_ACL;
    end else begin
      act = ACT_NONE;
    end
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      ch = 4'($urandom_range(CHANNELS, 15));
    end else if (pick < 60) begin
      ch = 4'(focus_ch);
    end else begin
      ch = 4'($urandom_range(0, CHANNELS - 1));
    end
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      tid = 7'($urandom_range(64, 127));
    end else if (pick < 75) begin
      tid = {1'b0, favored_tasks[$urandom_range(0, 3)]};
    end else begin
      tid = 7'($urandom_range(0, 63));
    end
    send_request(act, ch, {$urandom(), $urandom()}, tid, $urandom_range(0, 99) < 75);
  endtask

  // Response side: segments of always-ready, coin-flip and periodic stalls,
  // plus one long hold-off on request so the request side backs up.
  initial begin
    stall_mode_t mode;
    int          seg_left;
    int          period;
    int          cycle_count;
    mode = RX_ALWAYS;
    seg_left = 0;
    period = 2;
    cycle_count = 0;
    forever begin
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_STALL_CYCLES) @(posedge clk);
      end else begin
        if (seg_left == 0) begin
          mode = stall_mode_t'($urandom_range(0, 2));
          seg_left = $urandom_range(4, 60);
          period = $urandom_range(2, 5);
        end
        seg_left--;
        cycle_count++;
        case (mode)
          RX_ALWAYS:   out_ready <= 1'b1;
          RX_RANDOM:   out_ready <= 1'($urandom_range(0, 1));
          default:     out_ready <= (cycle_count % period) != 0;
        endcase
        @(posedge clk);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    request_mix_t mix;
    int           focus_ch;
    int           phase_len;
    int           burst_left;
    int           phase;
    bit           steady;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests. Grant the lowest and highest task on channel 0 and
    // push messages from each, from an unlisted task, and from two trusted ids.
    send_request(ACT_ACL, 4'd0, '0, 7'd0, 1'b1);
    send_request(ACT_ACL, 4'd0, '0, 7'd63, 1'b1);
    send_request(ACT_WRITE, 4'd0, {MSG_W{1'b1}}, 7'd0, 1'b0);
    send_request(ACT_WRITE, 4'd0, '0, 7'd63, 1'b1);
    send_request(ACT_WRITE, 4'd0, 64'h1234_5678_9abc_def0, 7'd5, 1'b0);
    send_request(ACT_WRITE, 4'd0, 64'ha5a5_a5a5_a5a5_a5a5, 7'h7f, 1'b0);
    send_request(ACT_WRITE, 4'd0, 64'h5a5a_5a5a_5a5a_5a5a, 7'h40, 1'b1);
    // Drain all four, then poll the now empty ring.
    repeat (5) send_request(ACT_POLL, 4'd0, '0, 7'd0, 1'b0);
    // Setting access with a trusted id changes no bit, so task 63 stays locked out.
    send_request(ACT_ACL, 4'd7, '0, 7'h7f, 1'b1);
    send_request(ACT_WRITE, 4'd7, 64'hdead_beef_0000_0001, 7'd63, 1'b0);
    // Revoke task 0 and watch its next write get refused.
    send_request(ACT_ACL, 4'd0, '0, 7'd0, 1'b0);
    send_request(ACT_WRITE, 4'd0, 64'h0000_0001_dead_beef, 7'd0, 1'b1);
    // Out-of-range channels for every action; the unused action ignores even those.
    send_request(ACT_WRITE, 4'd8, {MSG_W{1'b1}}, 7'h7f, 1'b1);
    send_request(ACT_POLL, 4'd15, '0, 7'd0, 1'b0);
    send_request(ACT_ACL, 4'd12, '0, 7'd3, 1'b1);
    send_request(ACT_NONE, 4'd15, {MSG_W{1'b1}}, 7'h7f, 1'b1);
    send_request(ACT_NONE, 4'd0, '0, 7'd0, 1'b0);
    send_request(ACT_WRITE, 4'd7, 64'h8000_0000_0000_0001, 7'h55, 1'b0);
    send_request(ACT_POLL, 4'd7, '0, 7'd0, 1'b0);

    foreach (favored_tasks[i]) begin
      favored_tasks[i] = 6'($urandom_range(0, 63));
    end
    useful_sent = 0;
    phase = 0;
    while (useful_sent < USEFUL_REQUESTS) begin
      mix = request_mix_t'($urandom_range(0, 2));
      focus_ch = $urandom_range(0, CHANNELS - 1);
      phase_len = $urandom_range(20, 120);
      steady = ($urandom_range(0, 3) == 0);
      favored_tasks[$urandom_range(0, 3)] = 6'($urandom_range(0, 63));
      if (phase == 1) begin
        // Back-to-back write-heavy requests against a long response hold-off fill the
        // block's internal queue and force the request side to stall.
        mix = MIX_FILL;
        steady = 1'b1;
        long_stall_req = 1'b1;
      end
      if (phase == 6) begin
        wait_for_all_responses();
      end
      burst_left = $urandom_range(1, 30);
      repeat (phase_len) begin
        if (useful_sent >= USEFUL_REQUESTS) begin
          break;
        end
        if (!steady && burst_left == 0) begin
          pause_sender($urandom_range(1, 8));
          burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        send_random_request(mix, focus_ch);
      end
      phase++;
    end

    wait_for_all_responses();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("multi_channel_mailbox_with_acl_core_test passed");
    end else begin
      $display("multi_channel_mailbox_with_acl_core_test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #2_000_000;
    $display("multi_channel_mailbox_with_acl_core_test failed");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/mcmb_pkg.sv
sv/mcmb_front.sv
sv/mcmb_queue.sv
sv/mcmb_back.sv
sv/multi_channel_mailbox_with_acl_core.sv
verif/mailbox_response_checker.sv
verif/multi_channel_mailbox_with_acl_core_test.sv
